[rtl/core/tss_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tss_pkg
// shared widths, action codes, controller states and the packet that walks
// the slot chain
// ---------------------------------------------------------------------------
package tss_pkg;

  localparam int SLOT_W   = 6;
  localparam int PRIO_W   = 8;
  localparam int MS_W     = 20;
  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 10;
  localparam int COUNT_W  = 6;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd10;
  localparam logic [COUNT_W-1:0]  WOKEN_MAX  = 6'd63;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_EXIT   = 2'd1,
    ACT_SLEEP  = 2'd2,
    ACT_WAKE   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LAUNCH,
    ST_RUN,
    ST_DONE
  } st_t;

  // one request travelling down the row of slot cells
  typedef struct packed {
    act_t               action;
    logic [SLOT_W-1:0]  slot;
    logic               slot_valid;
    logic [PRIO_W-1:0]  prio;
    logic [TICK_W-1:0]  now;
    logic [TICK_W-1:0]  deadline;
    logic               ok;
    logic [SLOT_W-1:0]  res_slot;
    logic [COUNT_W-1:0] count;
  } pkt_t;

endpackage

[rtl/core/tss_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tss_in_if
// request channel: one scheduler call per word
// ---------------------------------------------------------------------------
interface tss_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic [tss_pkg::SLOT_W-1:0]       task_slot;
  logic                             slot_valid;
  logic [tss_pkg::PRIO_W-1:0]       new_priority;
  logic [tss_pkg::MS_W-1:0]         sleep_ms;
  logic [tss_pkg::TICK_W-1:0]       now_tick;

  modport source (
    output valid, action, task_slot, slot_valid, new_priority, sleep_ms, now_tick,
    input  ready
  );
  modport sink (
    input  valid, action, task_slot, slot_valid, new_priority, sleep_ms, now_tick,
    output ready
  );
endinterface

[rtl/core/tss_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tss_out_if
// result channel: one result word per scheduler call
// ---------------------------------------------------------------------------
interface tss_out_if;
  logic                        valid;
  logic                        ready;
  logic [tss_pkg::SLOT_W-1:0]  result_slot;
  logic                        done_ok;
  logic [tss_pkg::COUNT_W-1:0] woken_count;

  modport source (
    output valid, result_slot, done_ok, woken_count,
    input  ready
  );
  modport sink (
    input  valid, result_slot, done_ok, woken_count,
    output ready
  );
endinterface

[rtl/core/tss_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tss_div
// restoring divider, one quotient bit per cycle, for sleep duration / period
// ---------------------------------------------------------------------------
module tss_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tss_pkg::MS_W-1:0]      dividend,
  input  logic [tss_pkg::PERIOD_W-1:0]  divisor,
  output logic                          done,
  output logic [tss_pkg::MS_W-1:0]      quot,
  output logic                          rem_nz
);
  localparam int MW  = tss_pkg::MS_W;
  localparam int PW  = tss_pkg::PERIOD_W;
  localparam int CW  = $clog2(MW);
  localparam logic [CW-1:0] LAST = CW'(MW - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] quo_r, quo_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] dvs_r, dvs_nxt;
  logic [PW:0]   trial;
  logic [PW:0]   diff;
  logic          ge;

  always_comb begin
    trial    = {rem_r, quo_r[MW-1]};
    ge       = trial >= {1'b0, dvs_r};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_nxt = ge ? diff[PW-1:0] : trial[PW-1:0];
      quo_nxt = {quo_r[MW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done   = done_r;
  assign quot   = quo_r;
  assign rem_nz = |rem_r;

endmodule

[rtl/core/tss_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tss_cell
// one task slot: occupied and sleeping flags, counter and priority; applies
// the passing request to itself and hands it to the next slot
// ---------------------------------------------------------------------------
module tss_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  tss_pkg::pkt_t pkt_in,
  output logic          vld_out,
  output tss_pkg::pkt_t pkt_out
);
  localparam int SW = tss_pkg::SLOT_W;
  localparam int TW = tss_pkg::TICK_W;
  localparam int PW = tss_pkg::PRIO_W;
  localparam bit IN_RANGE = INDEX < (1 << SW);
  localparam bit NOT_ROOT = INDEX != 0;
  localparam logic [SW-1:0] IDX_LO = SW'(INDEX);

  logic          used_r, used_nxt;
  logic          sleep_r, sleep_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] prio_r, prio_nxt;
  logic          vld_r;
  tss_pkg::pkt_t pkt_r, pkt_nxt;
  logic          match;

  always_comb begin
    match     = IN_RANGE && pkt_in.slot_valid && (pkt_in.slot == IDX_LO);
    used_nxt  = used_r;
    sleep_nxt = sleep_r;
    cnt_nxt   = cnt_r;
    prio_nxt  = prio_r;
    pkt_nxt   = pkt_in;
    if (vld_in) begin
      case (pkt_in.action)
        tss_pkg::ACT_CREATE: begin
          // first free slot along the row claims the request
          if (!used_r && !pkt_in.ok) begin
            used_nxt         = 1'b1;
            sleep_nxt        = 1'b0;
            prio_nxt         = pkt_in.prio;
            cnt_nxt          = TW'(pkt_in.prio);
            pkt_nxt.ok       = 1'b1;
            pkt_nxt.res_slot = IDX_LO;
          end
        end
        tss_pkg::ACT_EXIT: begin
          if (NOT_ROOT && match && used_r) begin
            used_nxt   = 1'b0;
            sleep_nxt  = 1'b0;
            pkt_nxt.ok = 1'b1;
          end
        end
        tss_pkg::ACT_SLEEP: begin
          if (match && used_r) begin
            sleep_nxt  = 1'b1;
            cnt_nxt    = pkt_in.deadline;
            pkt_nxt.ok = 1'b1;
          end
        end
        tss_pkg::ACT_WAKE: begin
          if (NOT_ROOT && used_r && sleep_r && (pkt_in.now >= cnt_r)) begin
            sleep_nxt = 1'b0;
            cnt_nxt   = TW'(prio_r);
            if (pkt_in.count != tss_pkg::WOKEN_MAX) begin
              pkt_nxt.count = pkt_in.count + 1'b1;
            end
          end
        end
        default: begin
          pkt_nxt = pkt_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      sleep_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      sleep_r <= sleep_nxt;
      vld_r   <= vld_in;
    end
    cnt_r  <= cnt_nxt;
    prio_r <= prio_nxt;
    if (vld_in) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign vld_out = vld_r;
  assign pkt_out = pkt_r;

endmodule

[rtl/core/task_slot_sleep_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// task_slot_sleep_table
// task slot table with create, exit, sleep and wakeup scan
// ---------------------------------------------------------------------------
// usage
//   in_ch carries one scheduler call per word: action, task_slot, slot_valid,
//   new_priority, sleep_ms and now_tick. out_ch returns one word per call:
//   result_slot, done_ok and woken_count, in call order.
//   cfg_wr_en / cfg_wr_data write tick_period_ms (a period of 0 acts as 1);
//   write it only while no call is in flight.
// call flow
//   a call walks the row of NUM_SLOTS slot cells, one cell per cycle, from the
//   launch state through the cells to the done state and output register.
//   sleep first runs the 20-step serial divider to form its deadline.
//   one call is in flight at a time; the next call is accepted once the
//   previous result is in the output register, even if it still waits on out_ch.
// reset
//   synchronous, active low: every slot free and ready, period back to 10;
//   in_ch.ready stays low while reset is held
// stall
//   a finished result waits in the controller until the output register
//   frees up; no new call is taken in that time
// ---------------------------------------------------------------------------
module task_slot_sleep_table #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tss_pkg::PERIOD_W-1:0] cfg_wr_data,
  tss_in_if.sink                       in_ch,
  tss_out_if.source                    out_ch
);
  localparam int TW = tss_pkg::TICK_W;
  localparam int MW = tss_pkg::MS_W;
  localparam int PW = tss_pkg::PERIOD_W;

  // tick period register
  logic [PW-1:0] period_r;
  logic [PW-1:0] divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= tss_pkg::PERIOD_RST;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  assign divisor = (period_r == '0) ? PW'(1) : period_r;

  // controller state
  tss_pkg::st_t  state_r, state_nxt;
  tss_pkg::pkt_t req_r, req_nxt;
  logic          accept;
  logic          div_start;
  logic          div_done;
  logic [MW-1:0] div_quot;
  logic          div_rem_nz;
  logic [TW:0]   dl_sum;
  logic          head_vld;
  logic          out_load;

  // chain wiring: index 0 feeds the first cell, the last one is the tail
  tss_pkg::pkt_t          chain_pkt [NUM_SLOTS+1];
  logic [NUM_SLOTS:0]     chain_vld;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [tss_pkg::SLOT_W-1:0]   out_slot_r;
  logic                         out_ok_r;
  logic [tss_pkg::COUNT_W-1:0]  out_count_r;

  assign accept    = in_ch.valid && in_ch.ready;
  assign div_start = accept && (in_ch.action == tss_pkg::ACT_SLEEP);

  tss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_ch.sleep_ms),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  // deadline = now + ceil(ms / period), clamped at the top of the tick range
  assign dl_sum = {1'b0, req_r.now} + (TW + 1)'(div_quot) + (TW + 1)'(div_rem_nz);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    in_ch.ready = 1'b0;
    head_vld    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      tss_pkg::ST_IDLE: begin
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          req_nxt.action     = tss_pkg::act_t'(in_ch.action);
          req_nxt.slot       = in_ch.task_slot;
          req_nxt.slot_valid = in_ch.slot_valid;
          req_nxt.prio       = in_ch.new_priority;
          req_nxt.now        = in_ch.now_tick;
          req_nxt.deadline   = in_ch.now_tick;
          // wakeup always reports success, the others earn it in a cell
          req_nxt.ok         = (in_ch.action == tss_pkg::ACT_WAKE);
          req_nxt.res_slot   = in_ch.task_slot;
          req_nxt.count      = '0;
          state_nxt = (in_ch.action == tss_pkg::ACT_SLEEP) ? tss_pkg::ST_DIV
                                                           : tss_pkg::ST_LAUNCH;
        end
      end
      tss_pkg::ST_DIV: begin
        if (div_done) begin
          req_nxt.deadline = dl_sum[TW] ? '1 : dl_sum[TW-1:0];
          state_nxt        = tss_pkg::ST_LAUNCH;
        end
      end
      tss_pkg::ST_LAUNCH: begin
        head_vld  = 1'b1;
        state_nxt = tss_pkg::ST_RUN;
      end
      tss_pkg::ST_RUN: begin
        if (chain_vld[NUM_SLOTS]) begin
          state_nxt = tss_pkg::ST_DONE;
        end
      end
      tss_pkg::ST_DONE: begin
        // tail packet holds its value until the next launch
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = tss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    req_r <= req_nxt;
  end

  // row of slot cells
  assign chain_vld[0] = head_vld;
  assign chain_pkt[0] = req_r;

  genvar g;
  for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
    tss_cell #(
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (chain_vld[g]),
      .pkt_in  (chain_pkt[g]),
      .vld_out (chain_vld[g+1]),
      .pkt_out (chain_pkt[g+1])
    );
  end

  // output stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_slot_r  <= chain_pkt[NUM_SLOTS].res_slot;
      out_ok_r    <= chain_pkt[NUM_SLOTS].ok;
      out_count_r <= chain_pkt[NUM_SLOTS].count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_slot = out_slot_r;
  assign out_ch.done_ok     = out_ok_r;
  assign out_ch.woken_count = out_count_r;

  // checks
  a_one_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld[NUM_SLOTS:1]))
    else $error("more than one request in the slot row");

  a_tail_run: assert property (@(posedge clk) disable iff (!rst_n)
    chain_vld[NUM_SLOTS] |-> state_r == tss_pkg::ST_RUN)
    else $error("request left the row outside the run state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == tss_pkg::ST_DIV)
    else $error("divider finished while nobody waits for it");

  a_sleep_div: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action == tss_pkg::ACT_SLEEP) |=> state_r == tss_pkg::ST_DIV)
    else $error("sleep call did not start the divider wait");

endmodule
